/* rtl/hla_pkg.sv */
// ---------------------------------------------------------------------------
// hla_pkg: shared types, constants and rom helpers for the hough accumulator
// holds field widths, command encoding and the cos/sin table functions
// ---------------------------------------------------------------------------
package hla_pkg;

  // default parameter values
  localparam int MAX_DIM_DEF    = 512;
  localparam int N_ANGLES_DEF   = 32;
  localparam int COUNT_BITS_DEF = 20;

  // fixed field widths
  localparam int PIX_W      = 9;
  localparam int CFG_W      = 10;
  localparam int RHO_IN_W   = 11;
  localparam int ANG_IN_W   = 5;
  localparam int OUT_W      = 20;
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 32;

  // fixed point
  localparam int Q_W     = 17;
  localparam int Q_FRAC  = 15;
  localparam int Q_HALF  = 16384;
  localparam int Q_ROUND = 32767;
  localparam int SUM_W   = 32;

  localparam logic [OUT_W-1:0] OUT_MAX = '1;

  localparam int QUEUE_DEPTH = 4;

  localparam longint Q28_ONE    = 64'sd268435456;
  localparam longint Q28_PI     = 64'sd843314857;
  localparam longint Q28_TWO_PI = 64'sd1686629713;

  // input mode codes
  localparam logic [1:0] MODE_VOTE  = 2'd0;
  localparam logic [1:0] MODE_READ  = 2'd1;
  localparam logic [1:0] MODE_CLEAR = 2'd2;

  typedef enum logic [1:0] {
    OP_VOTE,
    OP_READ,
    OP_CLEAR
  } hla_op_t;

  typedef struct packed {
    logic [CFG_W-1:0] rows;
    logic [CFG_W-1:0] cols;
  } hla_cfg_t;

  typedef struct packed {
    hla_op_t             op;
    logic [PIX_W-1:0]    col;
    logic [CFG_W-1:0]    y;
    logic [RHO_IN_W-1:0] rd_rho;
    logic [ANG_IN_W-1:0] rd_ang;
    logic                rd_err;
  } hla_cmd_t;

  // truncating division by the small series divisors
  function automatic longint hla_div_small(longint v, int d);
    case (d)
      1:  return v / 1;
      2:  return v / 2;
      3:  return v / 3;
      4:  return v / 4;
      5:  return v / 5;
      6:  return v / 6;
      7:  return v / 7;
      8:  return v / 8;
      9:  return v / 9;
      10: return v / 10;
      11: return v / 11;
      12: return v / 12;
      13: return v / 13;
      14: return v / 14;
      15: return v / 15;
      16: return v / 16;
      17: return v / 17;
      18: return v / 18;
      19: return v / 19;
      20: return v / 20;
      21: return v / 21;
      22: return v / 22;
      23: return v / 23;
      24: return v / 24;
      25: return v / 25;
      26: return v / 26;
      27: return v / 27;
      28: return v / 28;
      29: return v / 29;
      default: return v;
    endcase
  endfunction

  // taylor series in q28, elaboration time only
  function automatic longint hla_series(longint x, longint start, int idx0);
    longint term;
    longint sum;
    int     idx;
    int     i;
    term = start;
    sum  = start;
    idx  = idx0;
    for (i = 0; i < 14; i++) begin
      term = -hla_div_small((term * x) / Q28_ONE, idx);
      term = hla_div_small((term * x) / Q28_ONE, idx + 1);
      idx  = idx + 2;
      sum  = sum + term;
    end
    return sum;
  endfunction

  // q28 to q15, round half away from zero, magnitude capped at one
  function automatic int hla_to_q15(longint v);
    longint m;
    longint r;
    m = (v < 0) ? -v : v;
    r = (m + 64'sd4096) >>> 13;
    if (r > 64'sd32768) begin
      r = 64'sd32768;
    end
    return (v < 0) ? -int'(r) : int'(r);
  endfunction

endpackage

/* rtl/hough_line_accumulator.sv */
// ---------------------------------------------------------------------------
// hough_line_accumulator: hough line transform vote store
// classifier, command queue and accumulator sequencer with apb registers
// ---------------------------------------------------------------------------
// usage
//   input channel (in_valid / in_stall) carries one transaction per item:
//   mode 0 votes a set pixel over all angles, mode 1 reads one bin,
//   mode 2 clears the store, mode 3 and pixels that cannot vote are dropped
//   result channel (out_valid / out_stall) returns one transaction per read
//   registers image_rows at 0x0 and image_cols at 0x4, write only when idle
// throughput and ordering
//   a vote issues N_ANGLES angles, one a cycle, and at most one store
//   read-modify-write per angle on the store read and write ports; votes
//   follow each other with no gap; a read waits until the last vote angle
//   has left the 3-stage store pipeline; its result comes from a registered
//   store read, while an out-of-range read is answered without one
//   a clear sweeps all 4*MAX_DIM*N_ANGLES store entries, one entry a cycle
//   (65536 entries at defaults)
// reset
//   after reset the same sweep runs; in_stall stays high for its length
// stalls
//   a waiting result holds its register; votes keep running behind it, and
//   a full command queue raises in_stall
// ---------------------------------------------------------------------------
module hough_line_accumulator #(
  parameter int MAX_DIM    = hla_pkg::MAX_DIM_DEF,
  parameter int N_ANGLES   = hla_pkg::N_ANGLES_DEF,
  parameter int COUNT_BITS = hla_pkg::COUNT_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  // input channel
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [1:0]                     in_mode,
  input  logic [hla_pkg::PIX_W-1:0]      in_pixel_row,
  input  logic [hla_pkg::PIX_W-1:0]      in_pixel_col,
  input  logic                           in_pixel_set,
  input  logic [hla_pkg::RHO_IN_W-1:0]   in_read_rho,
  input  logic [hla_pkg::ANG_IN_W-1:0]   in_read_angle,
  // result channel
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [hla_pkg::OUT_W-1:0]      out_bin_count,
  output logic                           out_range_error,
  // configuration port
  input  logic                           cfg_psel,
  input  logic                           cfg_penable,
  input  logic                           cfg_pwrite,
  input  logic [hla_pkg::CFG_ADDR_W-1:0] cfg_paddr,
  input  logic [hla_pkg::CFG_DATA_W-1:0] cfg_pwdata,
  output logic [hla_pkg::CFG_DATA_W-1:0] cfg_prdata,
  output logic                           cfg_pready
);
  import hla_pkg::*;

  // reset dimension, clipped to the largest image
  localparam int DIM_RST = (MAX_DIM < 512) ? MAX_DIM : 512;

  logic [CFG_W-1:0] rows_r;
  logic [CFG_W-1:0] cols_r;
  logic [CFG_W-1:0] wdim;
  logic             cfg_write;
  hla_cfg_t         cfg;

  hla_cmd_t front_cmd;
  hla_cmd_t q_head;
  logic     front_keep;
  logic     q_full;
  logic     q_empty;
  logic     q_pop;
  logic     init_busy;
  logic     in_accept;

  // register file: bit 2 of the address picks the register
  assign cfg_pready = 1'b1;
  assign cfg_write  = cfg_psel && cfg_penable && cfg_pwrite;
  // written dimensions above the largest image saturate
  assign wdim = (32'(cfg_pwdata[CFG_W-1:0]) > 32'(MAX_DIM)) ? CFG_W'(MAX_DIM) :
                cfg_pwdata[CFG_W-1:0];
  assign cfg_prdata = cfg_paddr[2] ? CFG_DATA_W'(cols_r) : CFG_DATA_W'(rows_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rows_r <= CFG_W'(DIM_RST);
      cols_r <= CFG_W'(DIM_RST);
    end else if (cfg_write) begin
      if (cfg_paddr[2]) begin
        cols_r <= wdim;
      end else begin
        rows_r <= wdim;
      end
    end
  end

  assign cfg.rows = rows_r;
  assign cfg.cols = cols_r;

  // intake: stall while the queue is full or the reset sweep runs
  assign in_stall  = q_full || init_busy;
  assign in_accept = in_valid && !in_stall;

  hla_front #(
    .MAX_DIM  (MAX_DIM),
    .N_ANGLES (N_ANGLES)
  ) u_front (
    .in_mode       (in_mode),
    .in_pixel_row  (in_pixel_row),
    .in_pixel_col  (in_pixel_col),
    .in_pixel_set  (in_pixel_set),
    .in_read_rho   (in_read_rho),
    .in_read_angle (in_read_angle),
    .cfg           (cfg),
    .keep          (front_keep),
    .cmd           (front_cmd)
  );

  hla_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (in_accept && front_keep),
    .push_data (front_cmd),
    .pop       (q_pop),
    .full      (q_full),
    .empty     (q_empty),
    .head      (q_head)
  );

  // sequencer, store and result register
  hla_back #(
    .MAX_DIM    (MAX_DIM),
    .N_ANGLES   (N_ANGLES),
    .COUNT_BITS (COUNT_BITS)
  ) u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg             (cfg),
    .q_empty         (q_empty),
    .q_head          (q_head),
    .q_pop           (q_pop),
    .init_busy       (init_busy),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_bin_count   (out_bin_count),
    .out_range_error (out_range_error)
  );

endmodule

/* rtl/hla_front.sv */
// ---------------------------------------------------------------------------
// hla_front: input classifier
// drops items that cannot vote and turns the rest into back end commands
// ---------------------------------------------------------------------------
module hla_front #(
  parameter int MAX_DIM  = hla_pkg::MAX_DIM_DEF,
  parameter int N_ANGLES = hla_pkg::N_ANGLES_DEF
) (
  input  logic [1:0]                   in_mode,
  input  logic [hla_pkg::PIX_W-1:0]    in_pixel_row,
  input  logic [hla_pkg::PIX_W-1:0]    in_pixel_col,
  input  logic                         in_pixel_set,
  input  logic [hla_pkg::RHO_IN_W-1:0] in_read_rho,
  input  logic [hla_pkg::ANG_IN_W-1:0] in_read_angle,
  input  hla_pkg::hla_cfg_t            cfg,
  output logic                         keep,
  output hla_pkg::hla_cmd_t            cmd
);
  import hla_pkg::*;

  localparam int RHO_BINS = 4 * MAX_DIM;

  logic [CFG_W:0]   two_dim;
  logic [CFG_W+2:0] rho_p2;
  logic             vote_ok;

  always_comb begin
    two_dim = {(CFG_W+1)'(cfg.rows) + (CFG_W+1)'(cfg.cols)};
    rho_p2  = (CFG_W+3)'(in_read_rho) + (CFG_W+3)'(2);
    vote_ok = in_pixel_set && (CFG_W'(in_pixel_row) < cfg.rows) &&
              (CFG_W'(in_pixel_col) < cfg.cols);

    cmd.col    = in_pixel_col;
    cmd.y      = cfg.rows - CFG_W'(in_pixel_row) - CFG_W'(1);
    cmd.rd_rho = in_read_rho;
    cmd.rd_ang = in_read_angle;
    // limit is 2*(rows+cols)-2, compared as rho+2 > 2*(rows+cols)
    cmd.rd_err = (rho_p2 > {two_dim, 1'b0}) ||
                 (32'(in_read_angle) >= 32'(N_ANGLES)) ||
                 (32'(in_read_rho) >= 32'(RHO_BINS));

    case (in_mode)
      MODE_VOTE: begin
        cmd.op = OP_VOTE;
        keep   = vote_ok;
      end
      MODE_READ: begin
        cmd.op = OP_READ;
        keep   = 1'b1;
      end
      MODE_CLEAR: begin
        cmd.op = OP_CLEAR;
        keep   = 1'b1;
      end
      default: begin
        cmd.op = OP_VOTE;
        keep   = 1'b0;
      end
    endcase
  end

endmodule

/* rtl/hla_queue.sv */
// ---------------------------------------------------------------------------
// hla_queue: short command fifo
// decouples the classifier from the accumulator sequencer
// ---------------------------------------------------------------------------
module hla_queue #(
  parameter int DEPTH = hla_pkg::QUEUE_DEPTH
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  hla_pkg::hla_cmd_t push_data,
  input  logic              pop,
  output logic              full,
  output logic              empty,
  output hla_pkg::hla_cmd_t head
);
  import hla_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  hla_cmd_t         slot_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r;
  logic [PTR_W-1:0] rd_ptr_r;
  logic [CNT_W-1:0] count_r;
  logic             do_push;
  logic             do_pop;

  assign full    = (count_r == CNT_W'(DEPTH));
  assign empty   = (count_r == '0);
  assign head    = slot_r[rd_ptr_r];
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
      end
      case ({do_push, do_pop})
        2'b10:   count_r <= count_r + CNT_W'(1);
        2'b01:   count_r <= count_r - CNT_W'(1);
        default: count_r <= count_r;
      endcase
    end
  end

endmodule

/* rtl/hla_back.sv */
// ---------------------------------------------------------------------------
// hla_back: accumulator sequencer and store
// steps through the angles of a vote, serves reads and sweeps clears
// ---------------------------------------------------------------------------
module hla_back #(
  parameter int MAX_DIM    = hla_pkg::MAX_DIM_DEF,
  parameter int N_ANGLES   = hla_pkg::N_ANGLES_DEF,
  parameter int COUNT_BITS = hla_pkg::COUNT_BITS_DEF
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  hla_pkg::hla_cfg_t         cfg,
  input  logic                      q_empty,
  input  hla_pkg::hla_cmd_t         q_head,
  output logic                      q_pop,
  output logic                      init_busy,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic [hla_pkg::OUT_W-1:0] out_bin_count,
  output logic                      out_range_error
);
  import hla_pkg::*;

  localparam int RHO_BINS = 4 * MAX_DIM;
  localparam int DEPTH    = RHO_BINS * N_ANGLES;
  localparam int ADDR_W   = $clog2(DEPTH);
  localparam int ANG_W    = $clog2(N_ANGLES);
  localparam int PC_W     = PIX_W + 1 + Q_W;
  localparam int PS_W     = CFG_W + 1 + Q_W;

  typedef enum logic [1:0] {
    ST_CLR,
    ST_IDLE,
    ST_VOTE
  } state_t;

  // cos/sin table
  logic signed [Q_W-1:0] cos_tab [N_ANGLES];
  logic signed [Q_W-1:0] sin_tab [N_ANGLES];

  for (genvar k = 0; k < N_ANGLES; k++) begin : g_rom
    localparam longint XR = (Q28_TWO_PI * longint'(k)) / N_ANGLES;
    localparam longint XA = (XR > Q28_PI) ? XR - Q28_TWO_PI : XR;
    localparam int     CV = hla_to_q15(hla_series(XA, Q28_ONE, 1));
    localparam int     SV = hla_to_q15(hla_series(XA, XA, 2));
    assign cos_tab[k] = Q_W'(CV);
    assign sin_tab[k] = Q_W'(SV);
  end

  state_t              state_r;
  logic [ANG_W-1:0]    k_r;
  logic [PIX_W-1:0]    col_r;
  logic [CFG_W-1:0]    y_r;
  logic [ADDR_W-1:0]   clr_addr_r;
  logic                init_r;
  logic                rd_pend_r;
  logic                out_valid_r;
  logic [OUT_W-1:0]    out_bin_count_r;
  logic                out_range_error_r;

  // vote pipeline
  logic                   s1_v_r;
  logic [ANG_W-1:0]       k1_r;
  logic signed [PC_W-1:0] prod_c_r;
  logic signed [PS_W-1:0] prod_s_r;
  logic                   s2_v_r;
  logic [ADDR_W-1:0]      addr2_r;
  logic                   s3_v_r;
  logic [ADDR_W-1:0]      addr3_r;
  logic [COUNT_BITS-1:0]  rdata_r;

  logic [COUNT_BITS-1:0]  acc_mem [DEPTH];

  logic                    issue;
  logic                    k_last;
  logic                    clr_last;
  logic                    pipe_busy;
  logic                    can_vote;
  logic                    can_read;
  logic                    can_clear;
  logic signed [PC_W-1:0]  prod_c;
  logic signed [PS_W-1:0]  prod_s;
  logic signed [SUM_W-1:0] base_s;
  logic signed [SUM_W-1:0] t_sum;
  logic [SUM_W-1:0]        rho_full;
  logic                    rho_ok;
  logic [ADDR_W-1:0]       vote_addr;
  logic [ADDR_W-1:0]       read_addr;
  logic [ADDR_W-1:0]       mem_rd_addr;
  logic                    wr_en;
  logic [ADDR_W-1:0]       wr_addr;
  logic [COUNT_BITS-1:0]   wr_data;

  // dispatch
  always_comb begin
    issue     = (state_r == ST_VOTE);
    k_last    = (k_r == ANG_W'(N_ANGLES - 1));
    clr_last  = (clr_addr_r == ADDR_W'(DEPTH - 1));
    pipe_busy = s1_v_r || s2_v_r || s3_v_r;
    can_vote  = (q_head.op == OP_VOTE) &&
                ((state_r == ST_IDLE) || (issue && k_last));
    can_read  = (q_head.op == OP_READ) && (state_r == ST_IDLE) && !pipe_busy &&
                !out_valid_r && !rd_pend_r;
    can_clear = (q_head.op == OP_CLEAR) && (state_r == ST_IDLE) && !pipe_busy;
    q_pop     = !q_empty && (can_vote || can_read || can_clear);
  end

  // rho arithmetic
  always_comb begin
    prod_c   = $signed({1'b0, col_r}) * cos_tab[k_r];
    prod_s   = $signed({1'b0, y_r}) * sin_tab[k_r];
    base_s   = $signed(((SUM_W'(cfg.rows) + SUM_W'(cfg.cols)) << Q_FRAC) -
                       SUM_W'(Q_HALF));
    t_sum    = SUM_W'(prod_c_r) + SUM_W'(prod_s_r) + base_s;
    // ceiling of t / 2^15, negative sums land in bin zero
    rho_full = t_sum[SUM_W-1] ? '0 :
               (($unsigned(t_sum) + SUM_W'(Q_ROUND)) >> Q_FRAC);
    rho_ok   = (rho_full < SUM_W'(RHO_BINS));
    vote_addr = ADDR_W'(rho_full * SUM_W'(N_ANGLES) + SUM_W'(k1_r));
    read_addr = ADDR_W'(SUM_W'(q_head.rd_rho) * SUM_W'(N_ANGLES) +
                        SUM_W'(q_head.rd_ang));
    mem_rd_addr = s2_v_r ? addr2_r : read_addr;
  end

  // store write port: clear sweep or saturating increment
  always_comb begin
    if (state_r == ST_CLR) begin
      wr_en   = 1'b1;
      wr_addr = clr_addr_r;
      wr_data = '0;
    end else begin
      wr_en   = s3_v_r && (rdata_r != '1);
      wr_addr = addr3_r;
      wr_data = rdata_r + COUNT_BITS'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      acc_mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    rdata_r <= acc_mem[mem_rd_addr];
  end

  // pipeline payload
  always_ff @(posedge clk) begin
    k1_r     <= k_r;
    prod_c_r <= prod_c;
    prod_s_r <= prod_s;
    addr2_r  <= vote_addr;
    addr3_r  <= addr2_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
      s3_v_r <= 1'b0;
    end else begin
      s1_v_r <= issue;
      s2_v_r <= s1_v_r && rho_ok;
      s3_v_r <= s2_v_r;
    end
  end

  // sequencer and result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLR;
      clr_addr_r  <= '0;
      init_r      <= 1'b1;
      k_r         <= '0;
      rd_pend_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
      if (rd_pend_r) begin
        out_valid_r       <= 1'b1;
        out_range_error_r <= 1'b0;
        out_bin_count_r   <= (32'(rdata_r) > 32'(OUT_MAX)) ? OUT_MAX :
                             OUT_W'(rdata_r);
        rd_pend_r         <= 1'b0;
      end

      case (state_r)
        ST_CLR: begin
          clr_addr_r <= clr_addr_r + ADDR_W'(1);
          if (clr_last) begin
            state_r <= ST_IDLE;
            init_r  <= 1'b0;
          end
        end
        ST_VOTE: begin
          k_r <= k_r + ANG_W'(1);
          if (k_last) begin
            state_r <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          state_r <= ST_IDLE;
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase

      if (q_pop) begin
        case (q_head.op)
          OP_VOTE: begin
            state_r <= ST_VOTE;
            k_r     <= '0;
            col_r   <= q_head.col;
            y_r     <= q_head.y;
          end
          OP_READ: begin
            if (q_head.rd_err) begin
              out_valid_r       <= 1'b1;
              out_range_error_r <= 1'b1;
              out_bin_count_r   <= '0;
            end else begin
              rd_pend_r <= 1'b1;
            end
          end
          OP_CLEAR: begin
            state_r    <= ST_CLR;
            clr_addr_r <= '0;
          end
          default: begin
            state_r <= ST_IDLE;
          end
        endcase
      end
    end
  end

  assign init_busy       = init_r;
  assign out_valid       = out_valid_r;
  assign out_bin_count   = out_bin_count_r;
  assign out_range_error = out_range_error_r;

endmodule
